// ===== rtl/sm3_pkg.sv =====
// SM3 hash core package: payload structs, state enum, IV and round constants.
// No dependencies.
package sm3_pkg;

	typedef struct packed {
		logic [31:0] data_word;
		logic [2:0]  valid_bytes;
		logic        last_word;
	} sm3_in_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic        digest_last;
	} sm3_out_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD,
		ST_ROUND,
		ST_FOLD,
		ST_EMIT
	} sm3_state_t;

	localparam logic [31:0] TJ_LOW  = 32'h79cc4519;
	localparam logic [31:0] TJ_HIGH = 32'h7a879d8a;
	localparam logic [31:0] PAD_WORD = 32'h80000000;
	localparam logic [3:0]  LEN_HI_POS = 4'd14;

	localparam logic [255:0] IV = {
		32'h7380166f, 32'h4914b2b9, 32'h172442d7, 32'hda8a0600,
		32'ha96f30bc, 32'h163138aa, 32'he38dee4d, 32'hb0fb0e4e
	};

	function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] n);
		logic [63:0] d;
		d = {x, x} << n;
		return d[63:32];
	endfunction

	function automatic logic [31:0] perm0(input logic [31:0] x);
		return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
	endfunction

	function automatic logic [31:0] perm1(input logic [31:0] x);
		return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
	endfunction

endpackage

// ===== rtl/sm3_hash_core.sv =====
// SM3 hash core top level: word buffering, padding sequencer, one-round-per-cycle
// compression unit and digest output. Depends on sm3_pkg.
//
// Usage: message words are taken while the core is idle, one per cycle at best.
// A word that fills a 16-word block makes the core busy for the 64 rounds and
// the fold, so the sustained word rate is set by the single shared round unit.
// After the last word the core pads one word per cycle (the last word's block
// tail), runs one or two compressions and then offers the eight digest words in
// order straight from the chaining value registers; the input is not ready
// until the eighth word has been taken. Message schedule words are produced on
// the fly in a 16-word sliding window, one new word per round.
module sm3_hash_core (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  sm3_pkg::sm3_in_t in_data,
	output logic            out_valid,
	input  logic            out_ready,
	output sm3_pkg::sm3_out_t out_data
);

	sm3_pkg::sm3_state_t state_q, state_d;

	logic [31:0] w_q [16];      // schedule window, w_q[0] is W[j]
	logic [31:0] v_q [8];       // chaining value
	logic [31:0] r_q [8];       // working registers
	logic [3:0]  pos_q;
	logic [63:0] cnt_q;
	logic [5:0]  rnd_q;
	logic        fin_q;         // padding in progress / final compression pending
	logic        lenpend_q;     // padding bit has been merged
	logic        lenhi_q;       // length high word sits at position 14
	logic        donelen_q;     // length words written in the block just compressed
	logic [2:0]  emit_q;

	// word to push this cycle
	logic        push;
	logic [31:0] push_word;
	logic        acc;
	logic [2:0]  nb;
	logic [31:0] mask;
	logic [63:0] bits;
	logic [63:0] cnt_next;

	assign acc = in_valid && in_ready;
	assign nb  = (in_data.valid_bytes > 3'd4) ? 3'd4 : in_data.valid_bytes;
	assign bits = cnt_q << 3;

	always_comb begin
		unique case (nb)
			3'd0:    mask = 32'h00000000;
			3'd1:    mask = 32'hff000000;
			3'd2:    mask = 32'hffff0000;
			3'd3:    mask = 32'hffffff00;
			default: mask = 32'hffffffff;
		endcase
	end

	// select input or padding word
	always_comb begin
		push = 1'b0;
		push_word = 32'h0;
		cnt_next = cnt_q;
		if (acc) begin
			push = 1'b1;
			if (!in_data.last_word) begin
				push_word = in_data.data_word;
				cnt_next = cnt_q + 64'd4;
			end else begin
				cnt_next = cnt_q + {61'd0, nb};
				if (nb == 3'd4) push_word = in_data.data_word;
				else push_word = (in_data.data_word & mask) | (sm3_pkg::PAD_WORD >> {nb, 3'b000});
			end
		end else if (state_q == sm3_pkg::ST_PAD) begin
			push = 1'b1;
			if (!lenpend_q) push_word = sm3_pkg::PAD_WORD;
			else if (pos_q == sm3_pkg::LEN_HI_POS) push_word = bits[63:32];
			else if (pos_q == 4'd15 && lenhi_q) push_word = bits[31:0];
			else push_word = 32'h0;
		end
	end

	// round datapath
	logic [31:0] tj, a12, ss1, ss2, ff, gg, tt1, tt2, wn;
	always_comb begin
		tj  = (rnd_q < 6'd16) ? sm3_pkg::TJ_LOW : sm3_pkg::TJ_HIGH;
		a12 = sm3_pkg::rotl(r_q[0], 5'd12);
		ss1 = sm3_pkg::rotl(a12 + r_q[4] + sm3_pkg::rotl(tj, rnd_q[4:0]), 5'd7);
		ss2 = ss1 ^ a12;
		if (rnd_q < 6'd16) begin
			ff = r_q[0] ^ r_q[1] ^ r_q[2];
			gg = r_q[4] ^ r_q[5] ^ r_q[6];
		end else begin
			ff = (r_q[0] & r_q[1]) | (r_q[0] & r_q[2]) | (r_q[1] & r_q[2]);
			gg = (r_q[4] & r_q[5]) | (~r_q[4] & r_q[6]);
		end
		tt1 = ff + r_q[3] + ss2 + (w_q[0] ^ w_q[4]);
		tt2 = gg + r_q[7] + ss1 + w_q[0];
		wn  = sm3_pkg::perm1(w_q[0] ^ w_q[7] ^ sm3_pkg::rotl(w_q[13], 5'd15))
		      ^ sm3_pkg::rotl(w_q[3], 5'd7) ^ w_q[10];
	end

	// next state
	always_comb begin
		state_d = state_q;
		in_ready = 1'b0;
		unique case (state_q)
			sm3_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (acc) begin
					if (pos_q == 4'd15) state_d = sm3_pkg::ST_ROUND;
					else if (in_data.last_word) state_d = sm3_pkg::ST_PAD;
				end
			end
			sm3_pkg::ST_PAD: begin
				if (pos_q == 4'd15) state_d = sm3_pkg::ST_ROUND;
			end
			sm3_pkg::ST_ROUND: begin
				if (rnd_q == 6'd63) state_d = sm3_pkg::ST_FOLD;
			end
			sm3_pkg::ST_FOLD: begin
				if (!fin_q) state_d = sm3_pkg::ST_IDLE;
				else if (lenpend_q && pos_q == 4'd0 && donelen_q) state_d = sm3_pkg::ST_EMIT;
				else state_d = sm3_pkg::ST_PAD;
			end
			sm3_pkg::ST_EMIT: begin
				if (out_ready && emit_q == 3'd7) state_d = sm3_pkg::ST_IDLE;
			end
			default: state_d = sm3_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= sm3_pkg::ST_IDLE;
		else state_q <= state_d;
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			cnt_q <= '0;
			rnd_q <= '0;
			fin_q <= 1'b0;
			lenpend_q <= 1'b0;
			lenhi_q <= 1'b0;
			donelen_q <= 1'b0;
			emit_q <= '0;
			for (int i = 0; i < 8; i++) v_q[i] <= sm3_pkg::IV[255 - 32*i -: 32];
		end else begin
			if (push) begin
				pos_q <= pos_q + 4'd1;
				cnt_q <= cnt_next;
				if (acc && in_data.last_word) begin
					fin_q <= 1'b1;
					lenpend_q <= (nb != 3'd4);
				end else if (state_q == sm3_pkg::ST_PAD) begin
					lenpend_q <= 1'b1;
				end
				lenhi_q <= !acc && lenpend_q && pos_q == sm3_pkg::LEN_HI_POS;
				donelen_q <= lenhi_q && pos_q == 4'd15;
			end
			if (state_q == sm3_pkg::ST_ROUND) rnd_q <= rnd_q + 6'd1;
			if (state_q == sm3_pkg::ST_FOLD) begin
				for (int i = 0; i < 8; i++) v_q[i] <= v_q[i] ^ r_q[i];
			end
			if (state_q == sm3_pkg::ST_EMIT && out_ready) begin
				emit_q <= emit_q + 3'd1;
				if (emit_q == 3'd7) begin
					for (int i = 0; i < 8; i++) v_q[i] <= sm3_pkg::IV[255 - 32*i -: 32];
					cnt_q <= '0;
					fin_q <= 1'b0;
					lenpend_q <= 1'b0;
					lenhi_q <= 1'b0;
					donelen_q <= 1'b0;
				end
			end
		end
	end

	// schedule window and working registers
	always_ff @(posedge clk) begin
		if (push) w_q[pos_q] <= push_word;
		if (state_q == sm3_pkg::ST_ROUND) begin
			for (int i = 0; i < 15; i++) w_q[i] <= w_q[i + 1];
			w_q[15] <= wn;
			r_q[3] <= r_q[2];
			r_q[2] <= sm3_pkg::rotl(r_q[1], 5'd9);
			r_q[1] <= r_q[0];
			r_q[0] <= tt1;
			r_q[7] <= r_q[6];
			r_q[6] <= sm3_pkg::rotl(r_q[5], 5'd19);
			r_q[5] <= r_q[4];
			r_q[4] <= sm3_pkg::perm0(tt2);
		end else begin
			for (int i = 0; i < 8; i++) r_q[i] <= v_q[i];
		end
	end

	// digest output straight from the chaining value
	assign out_valid = (state_q == sm3_pkg::ST_EMIT);
	assign out_data.digest_word = v_q[emit_q];
	assign out_data.digest_last = (emit_q == 3'd7);

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid)) else $error("input taken while emitting");
	a_round_start: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != sm3_pkg::ST_ROUND) |-> (rnd_q == 6'd0)) else $error("round counter stray");
	a_fold_after: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sm3_pkg::ST_FOLD) |-> $past(rnd_q) == 6'd63) else $error("fold early");

endmodule
